### hdl/bb3_pkg.sv
// Shared constants, types and tables for the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
    localparam int FW_W        = 11;
    localparam int FH_W        = 16;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int WIN_N       = 9;
    localparam int SUM_W       = 12;
    localparam int NUM_W       = 4;
    localparam int DIVIDEND_W  = SUM_W + 1;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = DIVIDEND_W + RECIP_SHIFT;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(768);

    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_EMIT
    } t_state;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic [FW_W-1:0] width;
        logic [FH_W-1:0] height;
        logic            restart;
    } t_frame_cfg;

    // Which window rows and columns take part in the one or two results of an item.
    // Bit 0 of row_on is the top row, bit 0 of a column mask the oldest column.
    typedef struct packed {
        logic       first;
        logic       second;
        logic [2:0] row_on;
        logic [2:0] col_on_a;
        logic [2:0] col_on_b;
        logic       last;
    } t_plan;

    // ceil(2^17 / (2n)) for n = 1..9; floor(x * RECIP[n] >> 17) equals x / (2n) exactly
    // for every dividend below 2^13. Unused counts fall back to the entry for one.
    localparam logic [RECIP_SHIFT-1:0] RECIP [16] = '{
        RECIP_SHIFT'(65536), RECIP_SHIFT'(65536), RECIP_SHIFT'(32768), RECIP_SHIFT'(21846),
        RECIP_SHIFT'(16384), RECIP_SHIFT'(13108), RECIP_SHIFT'(10923), RECIP_SHIFT'(9363),
        RECIP_SHIFT'(8192),  RECIP_SHIFT'(7282),  RECIP_SHIFT'(65536), RECIP_SHIFT'(65536),
        RECIP_SHIFT'(65536), RECIP_SHIFT'(65536), RECIP_SHIFT'(65536), RECIP_SHIFT'(65536)
    };

endpackage

### hdl/bb3_if.sv
// Stream interfaces for pixel beats in and blurred pixel beats out.
interface bb3_pix_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            op;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, op, in_red, in_green, in_blue, input ready);
    modport sink (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_res_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

### hdl/bb3_ram.sv
// Generic simple dual-port RAM with a registered read port.
module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/bb3_cfg.sv
// APB register block holding the frame width and height.
module bb3_cfg import bb3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_frame_cfg         o_cfg
);

    logic [FW_W-1:0] r_width, n_width;
    logic [FH_W-1:0] r_height, n_height;
    logic            wr;
    t_reg_idx        idx;

    assign wr     = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[REG_SEL_BIT]);
    assign pready = 1'b1;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (wr) begin
            case (idx)
                REG_FRAME_WIDTH:  n_width  = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: n_height = pwdata[FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(r_width);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= FW_RESET;
            r_height <= FH_RESET;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    // Any write restarts the frame at the same edge that updates the register.
    assign o_cfg.width   = r_width;
    assign o_cfg.height  = r_height;
    assign o_cfg.restart = wr;

endmodule

### hdl/bb3_avg.sv
// Masked 3x3 color sums and rounded averaging by reciprocal multiplication.
module bb3_avg import bb3_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [WIN_N-1:0][PIX_W-1:0] i_win,
    input  logic [WIN_N-1:0]           i_mask,
    output logic [CH_W-1:0]            o_red,
    output logic [CH_W-1:0]            o_green,
    output logic [CH_W-1:0]            o_blue
);

    logic [2:0][SUM_W-1:0] r_sum, n_sum;
    logic [NUM_W-1:0]      r_n, n_n;
    logic [2:0][CH_W-1:0]  quot;

    // Channel 2 is red, 1 green, 0 blue, as packed in a pixel.
    always_comb begin
        logic [2:0][2:0][SUM_W-1:0] row_sum;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
                row_sum[ch][k] = '0;
                for (int j = 0; j < 3; j++) begin
                    if (i_mask[k*3+j]) begin
                        row_sum[ch][k] = row_sum[ch][k]
                                       + SUM_W'(i_win[k*3+j][ch*CH_W +: CH_W]);
                    end
                end
            end
            n_sum[ch] = row_sum[ch][0] + row_sum[ch][1] + row_sum[ch][2];
        end
        n_n = NUM_W'($countones(i_mask));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
            r_n   <= n_n;
        end
    end

    // Round half up: (2*sum + n) / (2*n).
    always_comb begin
        logic [DIVIDEND_W-1:0] dividend;
        logic [PROD_W-1:0]     prod;
        for (int ch = 0; ch < 3; ch++) begin
            dividend = {r_sum[ch], 1'b0} + DIVIDEND_W'(r_n);
            prod     = PROD_W'(dividend) * PROD_W'(RECIP[r_n]);
            quot[ch] = prod[RECIP_SHIFT +: CH_W];
        end
    end

    assign o_red   = quot[2];
    assign o_green = quot[1];
    assign o_blue  = quot[0];

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_load) |-> (r_n >= NUM_W'(1) && r_n <= NUM_W'(WIN_N)))
        else $error("neighbor count out of range after a sum load");

endmodule

### hdl/box_blur_3x3_rgb_core.sv
// Top level of the 3x3 RGB box blur: sequencer, window, line memory and output register.
// A pixel beat passes the line memory read and the window load; each of its results then passes
// the sum register and the output register, a second result (last column) after the first, and
// both wait on a stalled output. The next beat is taken only in idle; each beat reads and writes
// the line memory once (a drain beat only reads it), each result once through the averaging unit.
// Reset (synchronous, active low): sequencer, row and column counters, window and output valid
// clear; width and height return to 1024 and 768; the line memory keeps its contents.
module box_blur_3x3_rgb_core import bb3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bb3_pix_if.sink            i_pix,
    bb3_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_frame_cfg cfg;

    t_state                     r_state, n_state;
    logic [COL_W-1:0]           r_col, n_col;
    logic [FH_W-1:0]            r_row, n_row;
    logic [WIN_N-1:0][PIX_W-1:0] r_win, n_win;
    t_pix                       r_pix;
    t_plan                      r_plan, n_plan, plan_now;
    logic                       r_phase, n_phase;

    logic                       r_out_valid, n_out_valid;
    logic [CH_W-1:0]            r_out_red, r_out_green, r_out_blue;
    logic                       r_out_last;

    logic [WEFF_W-1:0]          w_eff;
    logic [FH_W-1:0]            h_eff;
    logic                       drain_now, kind_ok, accept, last_col;
    logic                       ram_we, ram_re;
    logic [LINE_W-1:0]          ram_rdata, ram_wdata;
    t_pix                       top_pix, mid_pix;
    logic [2:0]                 col_on;
    logic [WIN_N-1:0]           mask;
    logic                       avg_load, out_free, out_load;
    logic [CH_W-1:0]            avg_red, avg_green, avg_blue;

    bb3_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Each word holds two rows of one column: {row above the previous, previous row}.
    bb3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_col),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    bb3_avg u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (avg_load),
        .i_win   (r_win),
        .i_mask  (mask),
        .o_red   (avg_red),
        .o_green (avg_green),
        .o_blue  (avg_blue)
    );

    // Effective frame size: a width of zero acts as one, wider than the memory as its depth.
    always_comb begin
        if (cfg.width == '0) begin
            w_eff = WEFF_W'(1);
        end else if (int'(cfg.width) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(cfg.width);
        end
        h_eff = (cfg.height == '0) ? FH_W'(1) : cfg.height;
    end

    assign drain_now = (r_row >= h_eff);
    assign accept    = i_pix.valid & i_pix.ready;
    assign kind_ok   = ((i_pix.op == OP_DRAIN) == drain_now);
    assign last_col  = (WEFF_W'(r_col) + WEFF_W'(1)) >= w_eff;

    assign top_pix   = ram_rdata[LINE_W-1:PIX_W];
    assign mid_pix   = ram_rdata[PIX_W-1:0];
    assign ram_wdata = {mid_pix, r_pix};

    always_comb begin
        plan_now.first    = (r_row != '0) && (r_col != '0);
        plan_now.second   = (r_row != '0) && last_col;
        plan_now.row_on   = {~drain_now, 1'b1, (r_row >= FH_W'(2))};
        plan_now.col_on_a = {1'b1, 1'b1, (r_col >= COL_W'(2))};
        plan_now.col_on_b = {1'b1, (r_col != '0), 1'b0};
        plan_now.last     = drain_now;
    end

    always_comb begin
        col_on = r_phase ? r_plan.col_on_b : r_plan.col_on_a;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                mask[k*3+j] = r_plan.row_on[k] & col_on[j];
            end
        end
    end

    assign out_free = !r_out_valid || o_res.ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && kind_ok) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (plan_now.first || plan_now.second) ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (!r_phase && r_plan.second) ? S_SUM : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output and datapath control. The memory write of a beat, in the load state, lands before the
    // next beat can issue its read in the idle state, so no forwarding is needed.
    always_comb begin
        i_pix.ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        avg_load    = 1'b0;
        out_load    = 1'b0;
        n_col       = r_col;
        n_row       = r_row;
        n_win       = r_win;
        n_plan      = r_plan;
        n_phase     = r_phase;
        case (r_state)
            S_IDLE: begin
                i_pix.ready = 1'b1;
                ram_re      = accept && kind_ok;
            end
            S_LOAD: begin
                ram_we = !drain_now;
                for (int k = 0; k < 3; k++) begin
                    n_win[k*3+0] = r_win[k*3+1];
                    n_win[k*3+1] = r_win[k*3+2];
                end
                n_win[2] = top_pix;
                n_win[5] = mid_pix;
                n_win[8] = r_pix;
                n_plan   = plan_now;
                n_phase  = !plan_now.first;
                if (last_col) begin
                    n_col = '0;
                    n_row = drain_now ? '0 : r_row + FH_W'(1);
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_SUM: begin
                avg_load = 1'b1;
            end
            S_EMIT: begin
                out_load = out_free;
                if (out_free) begin
                    n_phase = 1'b1;
                end
            end
            default: ;
        endcase
        if (cfg.restart) begin
            n_col = '0;
            n_row = '0;
            n_win = '0;
        end
    end

    assign n_out_valid = out_load | (r_out_valid & ~o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_win       <= '0;
            r_plan      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_win       <= n_win;
            r_plan      <= n_plan;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix <= drain_now ? '0 : {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        end
        if (out_load) begin
            r_out_red   <= avg_red;
            r_out_green <= avg_green;
            r_out_blue  <= avg_blue;
            r_out_last  <= r_phase & r_plan.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_red    = r_out_red;
    assign o_res.out_green  = r_out_green;
    assign o_res.out_blue   = r_out_blue;
    assign o_res.frame_last = r_out_last;

    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("line memory read and write in the same cycle");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WEFF_W'(r_col) < w_eff)
        else $error("column counter beyond frame width");

    a_row_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_eff)
        else $error("row counter beyond drain row");

    a_emit_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && $past(r_state) != S_EMIT) |-> $past(r_state) == S_SUM)
        else $error("result emitted without a preceding sum");

endmodule
